// ===== sv/swm_pkg.sv =====
// ============================================================================
// swm_pkg: shared types and constants for the sliding window maximum core
// Default sizes, configuration register layout and the per-sample step
// control group that the core broadcasts to its cells.
// ============================================================================
package swm_pkg;

    // default sizes
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // window size register
    localparam int CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

    // control broadcast to every cell for one request
    typedef struct packed {
        logic accept;
        logic last;
    } swm_step_t;

endpackage

// ===== sv/swm_stream_if.sv =====
// ============================================================================
// swm_stream_if: valid/ready channels of the sliding window maximum core
// Sample channel (sample plus end-of-sequence flag) and result channel
// (window maximum), each with a source and a sink modport.
// ============================================================================
interface swm_sample_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swm_result_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

// ===== sv/swm_cell.sv =====
// ============================================================================
// swm_cell: one position of the sample shift line
// Holds the sample that arrived INDEX requests ago and whether it is still
// a deque entry. Each accepted request shifts the neighbor in and drops the
// entry if it left the window or does not beat the new sample.
// ============================================================================
module swm_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int KW           = 7,
    parameter int INDEX        = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swm_pkg::swm_step_t      step,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic [KW-1:0]           k,
    input  logic [SAMPLE_WIDTH-1:0] prev_value,
    input  logic                    prev_valid,
    output logic [SAMPLE_WIDTH-1:0] leaf_value,
    output logic                    leaf_valid,
    output logic [SAMPLE_WIDTH-1:0] value,
    output logic                    valid
);

    localparam bit HEAD = (INDEX == 0);

    logic [SAMPLE_WIDTH-1:0] value_reg;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    in_window;
    logic                    beats_sample;
    logic                    keep;

    // entry survives if still inside the window and strictly above the new sample
    assign in_window    = (k > KW'(INDEX));
    assign beats_sample = ($signed(prev_value) > $signed(sample));
    assign keep         = HEAD ? 1'b1 : (prev_valid && beats_sample && in_window);

    // state after this request, before an end-of-sequence clear
    assign leaf_value = prev_value;
    assign leaf_valid = keep;
    assign valid_next = keep && !step.last;

    // sample shift line
    always_ff @(posedge clk)
    begin
        if (step.accept)
        begin
            value_reg <= prev_value;
        end
    end

    // entry flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step.accept)
        begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== sv/swm_tree.sv =====
// ============================================================================
// swm_tree: registered selection tree over the cell row
// Picks the value of the oldest surviving entry (highest cell index), which
// is the deque front and so the window maximum. One register level per tree
// level; a tag bit travels alongside to mark requests that give a result.
// ============================================================================
module swm_tree #(
    parameter int N = 64,
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic [W-1:0] leaf_value [N],
    input  logic         leaf_valid [N],
    input  logic         in_tag,
    output logic [W-1:0] top_value,
    output logic         top_valid,
    output logic         top_tag
);

    localparam int LEVELS = $clog2(N);
    localparam int P      = 1 << LEVELS;
    localparam int NODES  = 2 * P - 1;

    // first node of a level in the flat node store
    function automatic int level_base(input int lvl);
        return 2 * P - 2 * (P >> lvl);
    endfunction

    logic [W-1:0]  node_value_reg [NODES];
    logic          node_valid_reg [NODES];
    logic [LEVELS:0] tag_reg;

    for (genvar l = 0; l <= LEVELS; l++)
    begin : g_level
        for (genvar j = 0; j < (P >> l); j++)
        begin : g_node
            localparam int IDX = level_base(l) + j;

            logic [W-1:0] value_next;
            logic         valid_next;

            if (l == 0)
            begin : g_leaf
                if (j < N)
                begin : g_real
                    assign value_next = leaf_value[j];
                    assign valid_next = leaf_valid[j];
                end
                else
                begin : g_pad
                    assign value_next = '0;
                    assign valid_next = 1'b0;
                end
            end
            else
            begin : g_pick
                localparam int LO = level_base(l - 1) + 2 * j;
                localparam int HI = LO + 1;

                // older half wins whenever it still holds an entry
                assign valid_next = node_valid_reg[LO] | node_valid_reg[HI];
                assign value_next = node_valid_reg[HI] ? node_value_reg[HI]
                                                       : node_value_reg[LO];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    node_value_reg[IDX] <= value_next;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    node_valid_reg[IDX] <= 1'b0;
                end
                else if (adv)
                begin
                    node_valid_reg[IDX] <= valid_next;
                end
            end
        end
    end

    // result tag follows the tree levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (adv)
        begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i <= LEVELS; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign top_value = node_value_reg[NODES-1];
    assign top_valid = node_valid_reg[NODES-1];
    assign top_tag   = tag_reg[LEVELS];

endmodule

// ===== sv/sliding_window_maximum_core.sv =====
// A result leaves once its sample is accepted and has passed every register
//   level of the registered selection tree, from the leaf level up to the root.
// Throughput: one sample per cycle; the cell row updates on each accepted sample
//   and the tree is fully pipelined, stalling only when the result is not taken.
// Reset: entry flags, fill count, tree and result flags clear at once;
//   window size returns to 3. Sample values are not reset.
// ============================================================================
// sliding_window_maximum_core: running maximum over the last K samples
// Monotonic deque kept in a row of shift cells: each cell drops its entry
// when it leaves the window or a newer sample is not smaller. The oldest
// surviving entry is the window maximum, found by a registered tree.
// ============================================================================
module sliding_window_maximum_core #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    swm_sample_if.sink                   samples,
    swm_result_if.source                 results,
    input  logic                         cfg_wr_en,
    input  logic [swm_pkg::CFG_WIDTH-1:0] cfg_wr_data
);

    import swm_pkg::*;

    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int KW = (FW > CFG_WIDTH) ? FW : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]    window_size_reg;
    logic [FW-1:0]           fill_reg;
    logic [FW-1:0]           fill_next;
    logic [FW-1:0]           fill_inc;
    logic [KW-1:0]           ws_ext;
    logic [KW-1:0]           k_eff;
    logic                    adv;
    logic                    produce;
    swm_step_t               step;

    logic [SAMPLE_WIDTH-1:0] sample_bits;
    logic [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]   cell_valid;
    logic [SAMPLE_WIDTH-1:0] leaf_value [WINDOW_MAX];
    logic                    leaf_valid [WINDOW_MAX];

    logic [SAMPLE_WIDTH-1:0] top_value;
    logic                    top_valid;
    logic                    top_tag;

    // handshake: the whole pipe moves unless a finished result is held
    assign adv           = !top_tag || results.ready;
    assign samples.ready = adv;
    assign step.accept   = samples.valid && adv;
    assign step.last     = samples.last_sample;
    assign sample_bits   = samples.sample;

    // effective window length
    assign ws_ext = KW'(window_size_reg);
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (ws_ext > KW'(WINDOW_MAX))
        begin
            k_eff = KW'(WINDOW_MAX);
        end
        else
        begin
            k_eff = ws_ext;
        end
    end

    // window size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_size_reg <= cfg_wr_data;
        end
    end

    // fill count of the current sequence, saturating
    assign fill_inc  = (fill_reg == FW'(WINDOW_MAX)) ? fill_reg : fill_reg + 1'b1;
    assign produce   = (KW'(fill_inc) >= k_eff);
    assign fill_next = step.last ? '0 : fill_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (step.accept)
        begin
            fill_reg <= fill_next;
        end
    end

    // cell row, newest sample enters cell 0
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [SAMPLE_WIDTH-1:0] prev_value;
        logic                    prev_valid;

        if (i == 0)
        begin : g_head
            assign prev_value = sample_bits;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_link
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .KW           (KW),
            .INDEX        (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (step),
            .sample     (sample_bits),
            .k          (k_eff),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .leaf_value (leaf_value[i]),
            .leaf_valid (leaf_valid[i]),
            .value      (cell_value[i]),
            .valid      (cell_valid[i])
        );
    end

    // front-of-deque selection
    swm_tree #(
        .N (WINDOW_MAX),
        .W (SAMPLE_WIDTH)
    ) u_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .leaf_value (leaf_value),
        .leaf_valid (leaf_valid),
        .in_tag     (step.accept && produce),
        .top_value  (top_value),
        .top_valid  (top_valid),
        .top_tag    (top_tag)
    );

    assign results.valid      = top_tag;
    assign results.window_max = top_value;

`ifndef SYNTHESIS
    // a new sample is always kept unless it ends the sequence
    a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
        step.accept && !step.last |=> cell_valid[0])
        else $error("newest sample not kept in cell 0");

    // end of sequence empties the deque and the fill count
    a_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step.accept && step.last |=> (cell_valid == '0) && (fill_reg == '0))
        else $error("deque not cleared after last sample");

    // never more entries than samples seen in the sequence
    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) <= int'(fill_reg))
        else $error("more deque entries than samples");

    // a result always comes from a real entry
    a_result_entry: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> top_valid)
        else $error("result without a deque entry");
`endif

endmodule
